@@ rtl/es2cal_pkg.sv @@
`timescale 1ns / 1ps

package es2cal_pkg;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    localparam int DAYS_W   = 16;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;

    // Day split of one word, passed from the front end to the calendar walk.
    typedef struct packed {
        logic [DAYS_W-1:0]   days;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } split_t;

    typedef struct packed {
        logic   valid;
        split_t data;
    } split_word_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DAYS,
        F_SOD,
        F_HOUR,
        F_HREM,
        F_MIN,
        F_MREM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_YEAR,
        B_MONTH,
        B_DONE
    } back_state_t;

endpackage

@@ rtl/es2cal_front.sv @@
`timescale 1ns / 1ps

module es2cal_front
    import es2cal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output split_word_t push,
    input  logic        push_ready
);

    // Reciprocals for division by a constant: (n * RECIP) >> SHIFT is exact over
    // the range of n that each stage sees.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, rounded up
    localparam logic [17:0] HOUR_RECIP = 18'd149131;    // 2^29 / 3600, rounded up
    localparam logic [12:0] MIN_RECIP  = 13'd4370;      // 2^18 / 60, rounded up

    front_state_t state_reg, state_next;

    logic [31:0]         rem_reg;
    logic [DAYS_W-1:0]   days_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] min_reg;

    logic [50:0] day_prod;
    logic [34:0] hour_prod;
    logic [24:0] min_prod;
    logic [31:0] day_back;
    logic [31:0] hour_back;
    logic [31:0] min_back;
    logic        accept;

    // Division by 86400 is a shift by seven and a division by 675. Each product
    // gets its own state, and so does each subtraction of quotient times divisor.
    always_comb begin
        day_prod  = 51'(rem_reg[31:7]) * 51'(DAY_RECIP);
        hour_prod = 35'(rem_reg[16:0]) * 35'(HOUR_RECIP);
        min_prod  = 25'(rem_reg[11:0]) * 25'(MIN_RECIP);
        day_back  = 32'(days_reg) * SECS_PER_DAY;
        hour_back = 32'(hour_reg) * SECS_PER_HOUR;
        min_back  = 32'(min_reg) * SECS_PER_MIN;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_valid) state_next = F_DAYS;
            F_DAYS: state_next = F_SOD;
            F_SOD:  state_next = F_HOUR;
            F_HOUR: state_next = F_HREM;
            F_HREM: state_next = F_MIN;
            F_MIN:  state_next = F_MREM;
            F_MREM: state_next = F_PUSH;
            F_PUSH: if (push_ready) state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = state_reg == F_IDLE;
        push.valid  = state_reg == F_PUSH;
        accept      = s_valid && s_ready;
        push.data.days   = days_reg;
        push.data.hour   = hour_reg;
        push.data.minute = min_reg;
        push.data.second = rem_reg[SECOND_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rem_reg <= s_epoch_seconds;
        end else if (state_reg == F_SOD) begin
            rem_reg <= rem_reg - day_back;
        end else if (state_reg == F_HREM) begin
            rem_reg <= rem_reg - hour_back;
        end else if (state_reg == F_MREM) begin
            rem_reg <= rem_reg - min_back;
        end
        if (state_reg == F_DAYS) begin
            days_reg <= day_prod[50:35];
        end
        if (state_reg == F_HOUR) begin
            hour_reg <= hour_prod[33:29];
        end
        if (state_reg == F_MIN) begin
            min_reg <= min_prod[23:18];
        end
    end

endmodule

@@ rtl/es2cal_queue.sv @@
`timescale 1ns / 1ps

module es2cal_queue
    import es2cal_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  split_word_t wr,
    output logic        wr_ready,
    output split_word_t rd,
    input  logic        rd_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    split_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    always_comb begin
        wr_ready = count_reg != CNT_W'(DEPTH);
        rd.valid = count_reg != '0;
        rd.data  = mem[rd_ptr_reg];
        do_push  = wr.valid && wr_ready;
        do_pop   = rd.valid && rd_ready;
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/es2cal_back.sv @@
`timescale 1ns / 1ps

module es2cal_back
    import es2cal_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  split_word_t         pop,
    output logic                pop_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [YEAR_W-1:0]   m_cal_year,
    output logic [MONTH_W-1:0]  m_cal_month,
    output logic [DAY_W-1:0]    m_cal_day,
    output logic [HOUR_W-1:0]   m_cal_hour,
    output logic [MINUTE_W-1:0] m_cal_minute,
    output logic [SECOND_W-1:0] m_cal_second
);

    localparam logic [YEAR_W-1:0]  BASE_YEAR  = 12'd1970;
    localparam logic [1:0]         BASE_MOD4  = 2'd2;
    localparam logic [6:0]         BASE_MOD100 = 7'd70;
    localparam logic [8:0]         BASE_MOD400 = 9'd370;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    back_state_t state_reg, state_next;

    logic [DAYS_W-1:0]  days_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [1:0]         mod4_reg;
    logic [6:0]         mod100_reg;
    logic [8:0]         mod400_reg;
    logic [MONTH_W-1:0] month_reg;
    split_t             tod_reg;
    logic               valid_reg;

    logic               leap;
    logic [8:0]         ylen;
    logic [DAY_W-1:0]   mlen;
    logic               year_fit;
    logic               month_done;
    logic               out_free;
    logic               take;
    logic               year_step;
    logic               month_step;
    logic               load_out;

    // Leap counters run alongside the year so no division is needed.
    always_comb begin
        leap       = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (mod4_reg == 2'd0));
        ylen       = leap ? 9'd366 : 9'd365;
        mlen       = month_len(month_reg, leap);
        year_fit   = days_reg < DAYS_W'(ylen);
        month_done = (month_reg == LAST_MONTH) || (days_reg < DAYS_W'(mlen));
        out_free   = !valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (pop.valid) state_next = B_YEAR;
            B_YEAR:  if (year_fit) state_next = B_MONTH;
            B_MONTH: if (month_done) state_next = B_DONE;
            B_DONE:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop_ready  = state_reg == B_IDLE;
        take       = pop_ready && pop.valid;
        year_step  = (state_reg == B_YEAR) && !year_fit;
        month_step = (state_reg == B_MONTH) && !month_done;
        load_out   = (state_reg == B_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            days_reg   <= pop.data.days;
            tod_reg    <= pop.data;
            year_reg   <= BASE_YEAR;
            mod4_reg   <= BASE_MOD4;
            mod100_reg <= BASE_MOD100;
            mod400_reg <= BASE_MOD400;
            month_reg  <= '0;
        end else if (year_step) begin
            days_reg   <= days_reg - DAYS_W'(ylen);
            year_reg   <= year_reg + 1'b1;
            mod4_reg   <= mod4_reg + 1'b1;
            mod100_reg <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 1'b1;
            mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 1'b1;
        end else if (month_step) begin
            days_reg  <= days_reg - DAYS_W'(mlen);
            month_reg <= month_reg + 1'b1;
        end
        if (load_out) begin
            m_cal_year   <= year_reg;
            m_cal_month  <= month_reg + 1'b1;
            m_cal_day    <= days_reg[DAY_W-1:0] + 1'b1;
            m_cal_hour   <= tod_reg.hour;
            m_cal_minute <= tod_reg.minute;
            m_cal_second <= tod_reg.second;
        end
    end

    assign m_valid = valid_reg;

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_MONTH) |-> (month_reg <= LAST_MONTH))
        else $error("month index ran past December");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DONE) |-> (days_reg < DAYS_W'(mlen)))
        else $error("day of month exceeds month length");

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_YEAR) |-> (year_reg <= 12'd2106))
        else $error("year walk ran past the 32-bit range");

    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (state_reg == B_IDLE) && valid_reg)
        else $error("result load did not present a word");

endmodule

@@ rtl/epoch_seconds_to_calendar_core.sv @@
`timescale 1ns / 1ps
// Timing: the front end and the back end each work on one word at a time. The year and
// month walks are longest for the last month of 2105.
// The front end accepts a new word only after pushing the last one; the back end walks the
// years after 1970, then the months before the result's month.
// Reset: aresetn is synchronous and active low; it empties the queue, idles both
// state machines and drops m_valid. No calendar state is kept between words.

module epoch_seconds_to_calendar_core
    import es2cal_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_epoch_seconds,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [YEAR_W-1:0]   m_cal_year,
    output logic [MONTH_W-1:0]  m_cal_month,
    output logic [DAY_W-1:0]    m_cal_day,
    output logic [HOUR_W-1:0]   m_cal_hour,
    output logic [MINUTE_W-1:0] m_cal_minute,
    output logic [SECOND_W-1:0] m_cal_second
);

    // The front end splits the count into whole days, hour, minute and second
    // by reciprocal multiplication, one product or subtraction per cycle.
    split_word_t push;
    logic        push_ready;

    // The back end walks off whole years, then whole months, one per cycle.
    split_word_t pop;
    logic        pop_ready;

    es2cal_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .push            (push),
        .push_ready      (push_ready)
    );

    // The queue lets the front end start on the next word while the back end
    // is still walking years for the previous one.
    es2cal_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (push),
        .wr_ready (push_ready),
        .rd       (pop),
        .rd_ready (pop_ready)
    );

    // The result sits in an output register, so the walk of the next word
    // can run while the current result waits for m_ready.
    es2cal_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop          (pop),
        .pop_ready    (pop_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cal_year   (m_cal_year),
        .m_cal_month  (m_cal_month),
        .m_cal_day    (m_cal_day),
        .m_cal_hour   (m_cal_hour),
        .m_cal_minute (m_cal_minute),
        .m_cal_second (m_cal_second)
    );

endmodule
